>>> rtl/cppm_pkg.sv
package cppm_pkg;

  localparam int TIMER_BITS  = 16;
  localparam int OVF_BITS    = 8;
  localparam int STAMP_BITS  = TIMER_BITS + OVF_BITS;
  localparam int OUT_BITS    = 23;
  localparam int CYC_BITS    = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = QPTR_BITS + 1;

  localparam logic [CYC_BITS-1:0] CYC_THRESH_RESET = CYC_BITS'(5);

  typedef enum logic [0:0] {
    OP_OVERFLOW = 1'b0,
    OP_CAPTURE  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_FALL   = 3'b100
  } phase_t;

  typedef struct packed {
    logic                report;
    logic [OUT_BITS-1:0] high_raw;
    logic [OUT_BITS-1:0] period;
    logic                rise_armed;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> rtl/cppm_if.sv
interface cppm_in_if;
  import cppm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [0:0]            opcode;
  logic [TIMER_BITS-1:0] capture_value;

  modport source (output valid, output opcode, output capture_value, input ready);
  modport sink   (input valid, input opcode, input capture_value, output ready);
endinterface

interface cppm_out_if;
  import cppm_pkg::*;

  logic                valid;
  logic                ready;
  logic                report_valid;
  logic [OUT_BITS-1:0] high_time;
  logic [OUT_BITS-1:0] period_time;
  logic                rising_edge_armed;

  modport source (output valid, output report_valid, output high_time, output period_time,
                  output rising_edge_armed, input ready);
  modport sink   (input valid, input report_valid, input high_time, input period_time,
                  input rising_edge_armed, output ready);
endinterface

>>> rtl/cppm_front.sv
module cppm_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cppm_pkg::CYC_BITS-1:0]       cfg_wdata,
  cppm_in_if.sink                             in_ch,
  input  cppm_pkg::q_status_t                 q_stat,
  output logic                                push,
  output cppm_pkg::entry_t                    push_entry
);
  import cppm_pkg::*;

  logic [CYC_BITS-1:0]   thresh_r;
  logic [OVF_BITS-1:0]   ovf_r, ovf_nxt;
  logic [CYC_BITS-1:0]   cyc_r, cyc_nxt;
  logic [CYC_BITS-1:0]   cyc_inc;
  phase_t                phase_r, phase_nxt;
  logic [STAMP_BITS-1:0] first_r, first_nxt;
  logic [STAMP_BITS-1:0] second_r, second_nxt;
  logic [STAMP_BITS-1:0] stamp;
  logic [STAMP_BITS-1:0] high_diff;
  logic [STAMP_BITS-1:0] period_diff;
  logic                  accept;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && !q_stat.full;
  assign push        = accept;

  assign stamp       = {ovf_r, in_ch.capture_value};
  assign high_diff   = stamp - second_r;
  assign period_diff = second_r - first_r;
  assign cyc_inc     = cyc_r + CYC_BITS'(1);

  always_comb begin
    ovf_nxt    = ovf_r;
    cyc_nxt    = cyc_r;
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    push_entry = '0;
    if (accept) begin
      case (opcode_t'(in_ch.opcode))
        OP_OVERFLOW: begin
          ovf_nxt = ovf_r + OVF_BITS'(1);
        end
        OP_CAPTURE: begin
          case (phase_r)
            PH_SECOND: begin
              second_nxt = stamp;
              phase_nxt  = PH_FALL;
            end
            PH_FALL: begin
              phase_nxt = PH_FIRST;
              if (cyc_inc >= thresh_r) begin
                push_entry.report   = 1'b1;
                push_entry.high_raw = high_diff[STAMP_BITS-1:1];
                push_entry.period   = period_diff[STAMP_BITS-1:1];
                cyc_nxt             = '0;
                ovf_nxt             = '0;
              end else begin
                cyc_nxt = cyc_inc;
              end
            end
            default: begin
              first_nxt = stamp;
              phase_nxt = PH_SECOND;
            end
          endcase
        end
        default: begin
          ovf_nxt = ovf_r;
        end
      endcase
    end
    push_entry.rise_armed = (phase_nxt != PH_FALL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= CYC_THRESH_RESET;
      ovf_r    <= '0;
      cyc_r    <= '0;
      phase_r  <= PH_FIRST;
    end else begin
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      ovf_r   <= ovf_nxt;
      cyc_r   <= cyc_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r  <= first_nxt;
    second_r <= second_nxt;
  end

endmodule

>>> rtl/cppm_queue.sv
module cppm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  cppm_pkg::entry_t     push_entry,
  input  logic                 pop,
  output cppm_pkg::entry_t     pop_entry,
  output cppm_pkg::q_status_t  q_stat
);
  import cppm_pkg::*;

  entry_t               mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_entry    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_BITS'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_BITS'(push) - QCNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> rtl/cppm_back.sv
module cppm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cppm_pkg::q_status_t  q_stat,
  input  cppm_pkg::entry_t     pop_entry,
  output logic                 pop,
  cppm_out_if.source           out_ch
);
  import cppm_pkg::*;

  logic                out_valid_r;
  logic                report_r;
  logic [OUT_BITS-1:0] high_r, high_nxt;
  logic [OUT_BITS-1:0] period_r;
  logic                edge_r;

  assign pop = !q_stat.empty && (!out_valid_r || out_ch.ready);

  // fold the high time back by one period when it overruns
  always_comb begin
    if (pop_entry.high_raw > pop_entry.period) begin
      high_nxt = pop_entry.high_raw - pop_entry.period;
    end else begin
      high_nxt = pop_entry.high_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      report_r <= pop_entry.report;
      high_r   <= high_nxt;
      period_r <= pop_entry.period;
      edge_r   <= pop_entry.rise_armed;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.report_valid      = report_r;
  assign out_ch.high_time         = high_r;
  assign out_ch.period_time       = period_r;
  assign out_ch.rising_edge_armed = edge_r;

endmodule

>>> rtl/capture_pulse_period_meter_unit.sv
// Path: a word accepted on in_ch is written into the queue, then popped into the output
// register that drives out_ch; it leaves once out_ch.ready is high. Throughput: one word
// per cycle unless the queue is full; the front tracks edge phase and timestamps, the back
// folds high time and holds the result register, a two-entry queue between them.
// Reset (rst_n low, synchronous): threshold back to 5, counters cleared, rising edge armed,
// queue and output register emptied.
module capture_pulse_period_meter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cppm_pkg::CYC_BITS-1:0]  cfg_wdata,
  cppm_in_if.sink                        in_ch,
  cppm_out_if.source                     out_ch
);
  import cppm_pkg::*;

  q_status_t q_stat;
  logic      push;
  logic      pop;
  entry_t    push_entry;
  entry_t    pop_entry;

  cppm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  cppm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  cppm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  a_report_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.report_valid |-> out_ch.rising_edge_armed)
    else $error("report word with falling edge armed");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.report_valid |-> out_ch.high_time == '0 && out_ch.period_time == '0)
    else $error("non-report word carries measurement");

  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !q_stat.empty)
    else $error("accepted word missing from queue");

endmodule
